// File: design/sha_pkg.sv
// sha-256 stream hasher: shared constants, command struct and round functions
// used by the controller, the datapath and the top level; no dependencies
`default_nettype none

package sha_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned LEN_WIDTH   = 61;
    localparam int unsigned PAD_LEN_POS = 56;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // source of the byte pushed into the block register
    localparam logic [1:0] BSEL_DATA = 2'd0;
    localparam logic [1:0] BSEL_MARK = 2'd1;
    localparam logic [1:0] BSEL_ZERO = 2'd2;
    localparam logic [1:0] BSEL_LEN  = 2'd3;

    localparam logic [7:0][31:0] INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic       push;
        logic [1:0] byte_sel;
        logic [2:0] len_idx;
        logic       len_inc;
        logic       init_work;
        logic       round;
        logic [5:0] round_idx;
        logic       add_chain;
        logic       restart;
        logic [2:0] out_idx;
    } t_dp_cmd;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

// File: design/sha_ctrl.sv
// sha-256 stream hasher controller: input and output handshakes, fill count,
// padding sequence and round counter; drives the datapath through t_dp_cmd
`default_nettype none

module sha_ctrl import sha_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire logic    i_byte_present,
    input  wire logic    i_end_of_message,
    output logic         o_valid,
    input  wire logic    i_stall,
    output logic [2:0]   o_word_index,
    output logic         o_final_word,
    output t_dp_cmd      o_cmd
);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [5:0] FILL_LAST = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0] RND_LAST  = 6'(ROUNDS - 1);
    localparam logic [5:0] LEN_POS   = 6'(PAD_LEN_POS);
    localparam logic [2:0] IDX_LAST  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [5:0] r_fill, n_fill;
    logic [5:0] r_rnd, n_rnd;
    logic       r_fin, n_fin;     // message is being closed
    logic       r_first, n_first; // pad mark still to be placed
    logic       r_last, n_last;   // current block carries the length
    logic [2:0] r_idx, n_idx;

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_rnd   = r_rnd;
        n_fin   = r_fin;
        n_first = r_first;
        n_last  = r_last;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.round_idx = r_rnd;
        o_cmd.out_idx   = r_idx;
        o_cmd.len_idx   = r_fill[2:0];

        case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    if (i_byte_present) begin
                        o_cmd.push     = 1'b1;
                        o_cmd.byte_sel = BSEL_DATA;
                        o_cmd.len_inc  = 1'b1;
                        n_fill         = r_fill + 6'd1;
                        if (r_fill == FILL_LAST) begin
                            o_cmd.init_work = 1'b1;
                            n_state = S_COMP;
                            n_rnd   = '0;
                            n_fin   = i_end_of_message;
                            n_first = i_end_of_message;
                        end else if (i_end_of_message) begin
                            n_state = S_PAD;
                            n_fin   = 1'b1;
                            n_first = 1'b1;
                        end
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                        n_fin   = 1'b1;
                        n_first = 1'b1;
                    end
                end
            end
            S_PAD: begin
                o_cmd.push = 1'b1;
                if (r_first) begin
                    o_cmd.byte_sel = BSEL_MARK;
                    n_first = 1'b0;
                    // mark fits before the length field: this is the last block
                    if (r_fill < LEN_POS) begin
                        n_last = 1'b1;
                    end
                end else if (r_last && r_fill >= LEN_POS) begin
                    o_cmd.byte_sel = BSEL_LEN;
                end else begin
                    o_cmd.byte_sel = BSEL_ZERO;
                end
                n_fill = r_fill + 6'd1;
                if (r_fill == FILL_LAST) begin
                    o_cmd.init_work = 1'b1;
                    n_state = S_COMP;
                    n_rnd   = '0;
                end
            end
            S_COMP: begin
                o_cmd.round = 1'b1;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == RND_LAST) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add_chain = 1'b1;
                if (!r_fin) begin
                    n_state = S_LOAD;
                end else if (r_last) begin
                    n_state = S_OUT;
                    n_idx   = '0;
                end else begin
                    // overflow block done, next block holds the length
                    n_state = S_PAD;
                    n_last  = 1'b1;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (r_idx == IDX_LAST) begin
                        o_cmd.restart = 1'b1;
                        n_state = S_LOAD;
                        n_fill  = '0;
                        n_fin   = 1'b0;
                        n_first = 1'b0;
                        n_last  = 1'b0;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_fill  <= '0;
            r_rnd   <= '0;
            r_fin   <= 1'b0;
            r_first <= 1'b0;
            r_last  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_rnd   <= n_rnd;
            r_fin   <= n_fin;
            r_first <= n_first;
            r_last  <= n_last;
            r_idx   <= n_idx;
        end
    end

    assign o_stall      = (r_state != S_LOAD);
    assign o_valid      = (r_state == S_OUT);
    assign o_word_index = r_idx;
    assign o_final_word = (r_idx == IDX_LAST);

endmodule

`default_nettype wire

// File: design/sha_dp.sv
// sha-256 stream hasher datapath: block shift register doubling as the
// message schedule window, working variables, chaining words, byte counter
`default_nettype none

module sha_dp import sha_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    input  wire logic [7:0]  i_data_byte,
    output logic [31:0]      o_digest_word
);

    localparam int unsigned BLK_W = BLOCK_BYTES * 8;

    logic [BLK_W-1:0]     r_blk;
    logic [7:0][31:0]     r_v;
    logic [7:0][31:0]     r_h;
    logic [LEN_WIDTH-1:0] r_len;

    logic [63:0] len_bits;
    logic [7:0]  push_byte;
    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] t1, t2;
    logic [31:0] ch, maj;

    assign len_bits = {r_len, 3'b000};

    always_comb begin
        case (i_cmd.byte_sel)
            BSEL_DATA: push_byte = i_data_byte;
            BSEL_MARK: push_byte = PAD_MARK;
            BSEL_LEN:  push_byte = len_bits[{~i_cmd.len_idx, 3'b000} +: 8];
            default:   push_byte = 8'h00;
        endcase
    end

    // window holds w[t] .. w[t+15], w[t] in the top word
    assign w0  = r_blk[BLK_W-1    -: 32];
    assign w1  = r_blk[BLK_W-33   -: 32];
    assign w9  = r_blk[BLK_W-289  -: 32];
    assign w14 = r_blk[BLK_W-449  -: 32];
    assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + big_sigma1(r_v[4]) + ch + ROUND_K[i_cmd.round_idx] + w0;
    assign t2  = big_sigma0(r_v[0]) + maj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_blk <= {r_blk[BLK_W-9:0], push_byte};
        end else if (i_cmd.round) begin
            r_blk <= {r_blk[BLK_W-33:0], w_new};
        end

        if (i_cmd.init_work) begin
            r_v <= r_h;
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h   <= INIT_HASH;
            r_len <= '0;
        end else begin
            if (i_cmd.restart) begin
                r_h <= INIT_HASH;
            end else if (i_cmd.add_chain) begin
                for (int k = 0; k < 8; k++) begin
                    r_h[k] <= r_h[k] + r_v[k];
                end
            end
            if (i_cmd.restart) begin
                r_len <= '0;
            end else if (i_cmd.len_inc) begin
                r_len <= r_len + LEN_WIDTH'(1);
            end
        end
    end

    assign o_digest_word = r_h[i_cmd.out_idx];

endmodule

`default_nettype wire

// File: design/sha256_stream_hasher.sv
// one byte item per cycle while a block fills; the item that fills a
// block is followed by a stall while the single round unit runs the 64 rounds
// and then one chain add. a closing item costs the padding bytes plus one or two
// compressions, then eight digest words, one per unstalled cycle.
// synchronous active-low reset loads the initial hash and clears all counters
`default_nettype none

module sha256_stream_hasher import sha_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_final_word
);

    t_dp_cmd cmd;

    sha_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_word_index     (o_word_index),
        .o_final_word     (o_final_word),
        .o_cmd            (cmd)
    );

    sha_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_data_byte),
        .o_digest_word (o_digest_word)
    );

endmodule

`default_nettype wire

// File: design/sha_chk.sv
// sha-256 stream hasher port checker and its bind to the top level;
// watches the digest sequence on the output channel
`default_nettype none

module sha_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_digest_word,
    input wire logic [2:0]  o_word_index,
    input wire logic        o_final_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digest_word) && $stable(o_word_index))
        else $error("digest item changed while stalled");

    a_final_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_final_word == (o_word_index == 3'd7)))
        else $error("final flag not on word seven");

    a_no_input_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while digest is out");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_final_word |=>
            o_valid && (o_word_index == 3'($past(o_word_index) + 3'd1)))
        else $error("digest words not in order");

    a_end_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_final_word |=> !o_valid)
        else $error("extra digest word after final");

endmodule

bind sha256_stream_hasher sha_chk u_sha_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_final_word  (o_final_word)
);

`default_nettype wire

// File: verif/sha256_stream_hasher_test.sv
// self-checking testbench for sha256_stream_hasher: byte items in, digest words out
// needs only the dut; a behavioral sha-256 predictor here builds the expected words
`default_nettype none

module sha256_stream_hasher_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 250;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_ITEMS  = 190;
    localparam int MAX_GAP       = 10;
    localparam int DIGEST_WORDS  = 8;
    localparam int BLOCK_SIZE    = 64;
    localparam int LEN_FIELD_POS = 56;
    localparam logic [7:0] PAD_MARKER = 8'h80;

    localparam logic [31:0] CHAIN_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         closing;
        logic         typed;
        logic [255:0] digest;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 13;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},          // idle item right after reset
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},    // empty message
        '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},      // "abc", last byte closes
        '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'ha5, 1'b0, 1'b0, 1'b0, 256'h0},          // idle item inside a message
        '{8'h00, 1'b0, 1'b1, 1'b0, 256'h0},          // empty final item closes it
        '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
        '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
        '{8'h5a, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},    // data ignored when no byte
        '{8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h7f, 1'b1, 1'b1, 1'b0, 256'h0}
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        final_flag;
    } digest_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_byte_present;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_final_word;

    sha256_stream_hasher dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_final_word     (o_final_word)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [31:0] hash_state [8];
    logic [7:0]  pend_bytes [64];
    int          pend_fill;
    logic [60:0] msg_len;
    logic [31:0] closed_digest [8];

    digest_word_t pending_words [$];

    int  mismatches = 0;
    int  cycles = 0;
    int  items_sent = 0;
    int  messages_closed = 0;
    int  words_checked = 0;
    int  input_stall_cycles = 0;
    bit  tx_burst = 1'b0;
    bit  hold_off_req = 1'b0;

    function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_hash();
        hash_state = CHAIN_IV;
        pend_fill  = 0;
        msg_len    = '0;
    endfunction

    function automatic void compress_pending();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {pend_bytes[4*t], pend_bytes[4*t+1], pend_bytes[4*t+2], pend_bytes[4*t+3]};
        for (int t = 16; t < 64; t++) begin
            s0 = rot_right(w[t-15], 7) ^ rot_right(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rot_right(w[t-2], 17) ^ rot_right(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        v = hash_state;
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + w[t];
            t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int k = 0; k < DIGEST_WORDS; k++)
            hash_state[k] = hash_state[k] + v[k];
    endfunction

    // returns 1 when the item closes a message; the digest lands in closed_digest
    function automatic bit hash_item(input logic [7:0] b, input logic present,
                                     input logic closing);
        logic [63:0] bit_len;
        if (present) begin
            pend_bytes[pend_fill] = b;
            pend_fill++;
            msg_len = msg_len + 61'd1;
            if (pend_fill == BLOCK_SIZE) begin
                compress_pending();
                pend_fill = 0;
            end
        end
        if (!closing)
            return 1'b0;
        pend_bytes[pend_fill] = PAD_MARKER;
        pend_fill++;
        // no room left for the length: pad out and spend an extra block
        if (pend_fill > LEN_FIELD_POS) begin
            while (pend_fill < BLOCK_SIZE) begin
                pend_bytes[pend_fill] = 8'h00;
                pend_fill++;
            end
            compress_pending();
            pend_fill = 0;
        end
        while (pend_fill < LEN_FIELD_POS) begin
            pend_bytes[pend_fill] = 8'h00;
            pend_fill++;
        end
        bit_len = {msg_len, 3'b000};
        for (int i = 0; i < 8; i++)
            pend_bytes[LEN_FIELD_POS + i] = bit_len[63 - 8*i -: 8];
        compress_pending();
        closed_digest = hash_state;
        restart_hash();
        return 1'b1;
    endfunction

    task automatic send_item(input logic [7:0] b, input logic present, input logic closing,
                             input logic typed, input logic [255:0] typed_digest);
        int gap;
        digest_word_t dw;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_data_byte      <= b;
        i_byte_present   <= present;
        i_end_of_message <= closing;
        @(posedge i_clk);
        while (o_stall) begin
            input_stall_cycles++;
            @(posedge i_clk);
        end
        items_sent++;
        if (hash_item(b, present, closing)) begin
            messages_closed++;
            for (int k = 0; k < DIGEST_WORDS; k++) begin
                dw.word       = typed ? typed_digest[255 - 32*k -: 32] : closed_digest[k];
                dw.index      = k[2:0];
                dw.final_flag = (k == DIGEST_WORDS - 1);
                pending_words.push_back(dw);
            end
        end
    endtask

    task automatic check_word();
        digest_word_t exp_w;
        if (pending_words.size() == 0) begin
            $error("digest word %h index %0d arrived with nothing expected",
                   o_digest_word, o_word_index);
            mismatches++;
        end else begin
            exp_w = pending_words.pop_front();
            words_checked++;
            if (o_digest_word !== exp_w.word) begin
                $error("digest_word: expected %h, got %h", exp_w.word, o_digest_word);
                mismatches++;
            end
            if (o_word_index !== exp_w.index) begin
                $error("word_index: expected %0d, got %0d", exp_w.index, o_word_index);
                mismatches++;
            end
            if (o_final_word !== exp_w.final_flag) begin
                $error("final_word: expected %0b, got %0b", exp_w.final_flag, o_final_word);
                mismatches++;
            end
        end
    endtask

    // output side: random stall per word, bursts without stall, one long hold-off
    initial begin
        int n;
        bit rx_burst;
        rx_burst = 1'b0;
        i_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if ($urandom_range(0, 11) == 0)
                    rx_burst = ~rx_burst;
                n = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            check_word();
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d digest words outstanding",
                     cycles, pending_words.size());
            $display("sha256_stream_hasher_test: done, errors");
            $finish;
        end
    end

    initial begin
        int boundary_len [$];
        int rand_items;
        int msg_len_pick;
        int pick;
        bit close_on_byte;

        boundary_len = '{55, 56, 64};
        rand_items = 0;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_data_byte      <= 8'h00;
        i_byte_present   <= 1'b0;
        i_end_of_message <= 1'b0;
        restart_hash();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r])
            send_item(DIRECTED[r].data, DIRECTED[r].present, DIRECTED[r].closing,
                      DIRECTED[r].typed, DIRECTED[r].digest);

        // first messages go back to back while the receiver holds off
        hold_off_req = 1'b1;
        while (rand_items < RANDOM_ITEMS || boundary_len.size() != 0) begin
            tx_burst = (messages_closed < DIRECTED_ROWS) ? 1'b1 : ($urandom_range(0, 3) == 0);
            if (boundary_len.size() != 0 && (rand_items > 150 || $urandom_range(0, 3) == 0)) begin
                pick = $urandom_range(0, boundary_len.size() - 1);
                msg_len_pick = boundary_len[pick];
                boundary_len.delete(pick);
            end else begin
                msg_len_pick = $urandom_range(0, 12);
            end
            close_on_byte = (msg_len_pick != 0) && ($urandom_range(0, 1) == 1);
            for (int n = 0; n < msg_len_pick; n++) begin
                if ($urandom_range(0, 7) == 0)
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
                send_item(8'($urandom_range(0, 255)), 1'b1,
                          close_on_byte && (n == msg_len_pick - 1), 1'b0, '0);
                rand_items++;
            end
            if (!close_on_byte) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
                rand_items++;
            end
        end
        i_valid <= 1'b0;

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d items sent, %0d messages hashed, %0d digest words compared",
                 items_sent, messages_closed, words_checked);
        $display("input held back for %0d cycles, %0d mismatches", input_stall_cycles,
                 mismatches);
        if (mismatches == 0)
            $display("sha256_stream_hasher_test: done, clean");
        else
            $display("sha256_stream_hasher_test: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
